// ===== sv/lphs_pkg.sv =====
// lphs_pkg: shared types and codes for the linear-probe hash set.
// No dependencies; used by the channel interfaces and the top level.
package lphs_pkg;

   localparam int unsigned KEY_WIDE_W   = 64;
   localparam int unsigned KEY_NARROW_W = 32;
   localparam int unsigned HANDLE_W     = 32;
   localparam int unsigned CMD_W        = 2;
   localparam int unsigned STATUS_W     = 3;
   localparam int unsigned SLOT_W       = 10;
   localparam int unsigned USED_W       = 10;

   typedef logic [CMD_W-1:0]        cmd_type;
   typedef logic [KEY_WIDE_W-1:0]   key_wide_type;
   typedef logic [KEY_NARROW_W-1:0] key_narrow_type;
   typedef logic [HANDLE_W-1:0]     handle_type;
   typedef logic [STATUS_W-1:0]     status_type;
   typedef logic [SLOT_W-1:0]       slot_type;
   typedef logic [USED_W-1:0]       used_type;

   localparam cmd_type CMD_LOOKUP = 2'd0;
   localparam cmd_type CMD_INSERT = 2'd1;
   localparam cmd_type CMD_CLEAR  = 2'd2;

   localparam status_type STAT_HIT      = 3'd0;
   localparam status_type STAT_MISS     = 3'd1;
   localparam status_type STAT_NEW      = 3'd2;
   localparam status_type STAT_REPLACED = 3'd3;
   localparam status_type STAT_FULL     = 3'd4;
   localparam status_type STAT_CLEARED  = 3'd5;

   // one table slot as stored in the RAM
   typedef struct packed {
      logic           valid;
      key_wide_type   key_upper;
      key_wide_type   key_middle;
      key_narrow_type key_lower;
      handle_type     handle;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

endpackage

// ===== sv/lphs_req_if.sv =====
// lphs_req_if: request channel (valid/ready plus command, key and handle).
// Depends on lphs_pkg.
interface lphs_req_if;
   import lphs_pkg::*;

   logic           valid;
   logic           ready;
   cmd_type        cmd;
   key_wide_type   key_upper;
   key_wide_type   key_middle;
   key_narrow_type key_lower;
   handle_type     object_handle;

   modport source (output valid, cmd, key_upper, key_middle, key_lower, object_handle,
                   input ready);
   modport sink   (input valid, cmd, key_upper, key_middle, key_lower, object_handle,
                   output ready);
endinterface

// ===== sv/lphs_rsp_if.sv =====
// lphs_rsp_if: response channel (valid/ready plus status, handle, slot, count).
// Depends on lphs_pkg.
interface lphs_rsp_if;
   import lphs_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   handle_type found_handle;
   slot_type   slot_index;
   used_type   entries_used;

   modport source (output valid, status, found_handle, slot_index, entries_used,
                   input ready);
   modport sink   (input valid, status, found_handle, slot_index, entries_used,
                   output ready);
endinterface

// ===== sv/lphs_ram.sv =====
// lphs_ram: generic single-clock RAM, one write and one read port,
// registered read data. No dependencies.
module lphs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== sv/linear_probe_hash_set_top.sv =====
// linear_probe_hash_set_top: open-addressing hash set, linear probing, one slot RAM.
// Depends on lphs_pkg, lphs_req_if, lphs_rsp_if, lphs_ram.
//
//   channel   dir  handshake            payload
//   req_chan  in   valid/ready          cmd, key_upper, key_middle, key_lower, object_handle
//   rsp_chan  out  valid/ready          status, found_handle, slot_index, entries_used
//
// Lookup/insert: after accept, one RAM read per slot probed, from the home slot on.
// Clear: after accept, every RAM row is written empty in turn, one row per cycle.
// After reset the same sweep runs with req ready low.
// Response sits in an output register; a request finishing while it is
// still held waits in place until rsp_chan.ready frees it.
module linear_probe_hash_set_top #(
   parameter int unsigned CAPACITY = 1024
) (
   input logic         clock,
   input logic         reset,
   lphs_req_if.sink    req_chan,
   lphs_rsp_if.source  rsp_chan
);
   import lphs_pkg::*;

   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(CAPACITY - 1);
   localparam logic [IDX_W-1:0] LOAD_LIMIT = IDX_W'(CAPACITY / 2);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PROBE = 2'd1;
   localparam logic [1:0] ST_CLEAR = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] probes_ff, probes_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic             clr_rsp_ff, clr_rsp_in;
   cmd_type          cmd_ff, cmd_in;
   key_wide_type     key_upper_ff, key_upper_in;
   key_wide_type     key_middle_ff, key_middle_in;
   key_narrow_type   key_lower_ff, key_lower_in;
   handle_type       handle_ff, handle_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   handle_type       rsp_handle_ff, rsp_handle_in;
   slot_type         rsp_slot_ff, rsp_slot_in;
   used_type         rsp_used_ff, rsp_used_in;
   logic             rsp_load;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_entry;
   logic [IDX_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type        rd_entry;

   logic             accept;
   logic             rsp_free;
   logic             key_eq;
   logic             slot_empty;
   logic             exhausted;
   logic             probe_done;
   logic [IDX_W-1:0] home;

   lphs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign home           = req_chan.key_upper[32 +: IDX_W];

   assign rd_entry   = entry_type'(rd_data);
   assign slot_empty = !rd_entry.valid;
   assign key_eq     = rd_entry.valid && (rd_entry.key_upper == key_upper_ff)
                       && (rd_entry.key_middle == key_middle_ff)
                       && (rd_entry.key_lower == key_lower_ff);
   assign exhausted  = !slot_empty && !key_eq && (probes_ff == LAST_IDX);
   assign probe_done = slot_empty || key_eq || exhausted;

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      probes_in     = probes_ff;
      count_in      = count_ff;
      clr_rsp_in    = clr_rsp_ff;
      cmd_in        = cmd_ff;
      key_upper_in  = key_upper_ff;
      key_middle_in = key_middle_ff;
      key_lower_in  = key_lower_ff;
      handle_in     = handle_ff;
      rd_addr       = pos_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_entry      = '0;
      rsp_load      = 1'b0;
      rsp_status_in = STAT_MISS;
      rsp_handle_in = '0;
      rsp_slot_in   = '0;
      rsp_used_in   = used_type'(count_ff);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in        = req_chan.cmd;
               key_upper_in  = req_chan.key_upper;
               key_middle_in = req_chan.key_middle;
               key_lower_in  = req_chan.key_lower;
               handle_in     = req_chan.object_handle;
               if (req_chan.cmd == CMD_CLEAR) begin
                  pos_in     = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = ST_CLEAR;
               end else begin
                  pos_in    = home;
                  rd_addr   = home;
                  probes_in = '0;
                  state_in  = ST_PROBE;
               end
            end
         end

         ST_PROBE: begin
            if (probe_done) begin
               if (rsp_free) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
                  if (cmd_ff == CMD_INSERT) begin
                     if (key_eq) begin
                        wr_en          = 1'b1;
                        wr_entry       = rd_entry;
                        wr_entry.handle = handle_ff;
                        rsp_status_in  = STAT_REPLACED;
                        rsp_handle_in  = rd_entry.handle;
                        rsp_slot_in    = slot_type'(pos_ff);
                     end else if (exhausted || (count_ff >= LOAD_LIMIT)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        wr_en               = 1'b1;
                        wr_entry.valid      = 1'b1;
                        wr_entry.key_upper  = key_upper_ff;
                        wr_entry.key_middle = key_middle_ff;
                        wr_entry.key_lower  = key_lower_ff;
                        wr_entry.handle     = handle_ff;
                        count_in            = count_ff + 1'b1;
                        rsp_status_in       = STAT_NEW;
                        rsp_slot_in         = slot_type'(pos_ff);
                        rsp_used_in         = used_type'(count_ff + 1'b1);
                     end
                  end else if (key_eq) begin
                     rsp_status_in = STAT_HIT;
                     rsp_handle_in = rd_entry.handle;
                     rsp_slot_in   = slot_type'(pos_ff);
                  end else begin
                     rsp_status_in = STAT_MISS;
                     rsp_slot_in   = exhausted ? '0 : slot_type'(pos_ff);
                  end
               end
            end else begin
               pos_in    = pos_ff + 1'b1;
               probes_in = probes_ff + 1'b1;
               rd_addr   = pos_ff + 1'b1;
            end
         end

         ST_CLEAR: begin
            wr_en = 1'b1;
            if (pos_ff == LAST_IDX) begin
               if (!clr_rsp_ff) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else if (rsp_free) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = STAT_CLEARED;
                  rsp_used_in   = '0;
                  count_in      = '0;
                  clr_rsp_in    = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pos_ff       <= '0;
         probes_ff    <= '0;
         count_ff     <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         probes_ff    <= probes_in;
         count_ff     <= count_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_upper_ff  <= key_upper_in;
      key_middle_ff <= key_middle_in;
      key_lower_ff  <= key_lower_in;
      handle_ff     <= handle_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_used_ff   <= rsp_used_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.found_handle = rsp_handle_ff;
   assign rsp_chan.slot_index   = rsp_slot_ff;
   assign rsp_chan.entries_used = rsp_used_ff;

endmodule

// ===== tb/sv/tb_linear_probe_hash_set_top.sv =====
`timescale 1ns / 1ps
// tb_linear_probe_hash_set_top: self-checking bench for the linear-probe hash set.
// A scoreboard keeps its own copy of the table and checks every response in order.
// Depends on lphs_pkg, lphs_req_if, lphs_rsp_if and linear_probe_hash_set_top.
module tb_linear_probe_hash_set_top;
   import lphs_pkg::*;

   localparam int unsigned TABLE_SLOTS = 1024;
   localparam int unsigned LOAD_LIMIT  = TABLE_SLOTS / 2;
   localparam int unsigned CYCLE_LIMIT = 4000000;
   localparam int unsigned REPORT_MAX  = 10;
   localparam int unsigned HOLD_CYCLES = 400;

   // spare command code, behaves as a lookup
   localparam cmd_type CMD_SPARE = 2'd3;

   typedef struct packed {
      key_wide_type   upper;
      key_wide_type   middle;
      key_narrow_type lower;
   } hash_key_type;

   typedef struct packed {
      cmd_type      cmd;
      hash_key_type key;
      handle_type   handle;
   } set_request_type;

   typedef struct packed {
      status_type status;
      handle_type found_handle;
      slot_type   slot_index;
      used_type   entries_used;
   } set_response_type;

   class hash_set_scoreboard;
      bit               occupied[TABLE_SLOTS];
      hash_key_type     stored_key[TABLE_SLOTS];
      handle_type       stored_handle[TABLE_SLOTS];
      int unsigned      entry_total;
      int unsigned      mismatch_total;
      set_response_type expected_rsp[$];

      function new();
         foreach (occupied[i]) occupied[i] = 1'b0;
         entry_total    = 0;
         mismatch_total = 0;
      endfunction

      function set_response_type predict_response(set_request_type req);
         set_response_type rsp;
         int unsigned      pos;
         int unsigned      probes;
         bit               hit;
         bit               empty_seen;
         rsp = '0;
         if (req.cmd == CMD_CLEAR) begin
            foreach (occupied[i]) occupied[i] = 1'b0;
            entry_total = 0;
            rsp.status  = STAT_CLEARED;
         end else begin
            pos        = req.key.upper[63:32] % TABLE_SLOTS;
            probes     = 0;
            hit        = 1'b0;
            empty_seen = 1'b0;
            while (!hit && !empty_seen && probes < TABLE_SLOTS) begin
               if (!occupied[pos]) begin
                  empty_seen = 1'b1;
               end else if (stored_key[pos] == req.key) begin
                  hit = 1'b1;
               end else begin
                  pos = (pos + 1) % TABLE_SLOTS;
                  probes++;
               end
            end
            if (!hit && !empty_seen) pos = 0;
            if (req.cmd == CMD_INSERT) begin
               if (hit) begin
                  rsp.found_handle   = stored_handle[pos];
                  stored_handle[pos] = req.handle;
                  rsp.status         = STAT_REPLACED;
               end else if (entry_total >= LOAD_LIMIT || !empty_seen) begin
                  pos        = 0;
                  rsp.status = STAT_FULL;
               end else begin
                  occupied[pos]      = 1'b1;
                  stored_key[pos]    = req.key;
                  stored_handle[pos] = req.handle;
                  entry_total++;
                  rsp.status = STAT_NEW;
               end
            end else if (hit) begin
               rsp.found_handle = stored_handle[pos];
               rsp.status       = STAT_HIT;
            end else begin
               rsp.status = STAT_MISS;
            end
            rsp.slot_index = slot_type'(pos);
         end
         rsp.entries_used = used_type'(entry_total);
         return rsp;
      endfunction

      function void note_request(set_request_type req);
         expected_rsp.push_back(predict_response(req));
      endfunction

      function void check_response(set_response_type got);
         set_response_type want;
         if (expected_rsp.size() == 0) begin
            if (mismatch_total < REPORT_MAX)
               $display("unexpected response: status %0d handle %h slot %0d used %0d",
                        got.status, got.found_handle, got.slot_index, got.entries_used);
            mismatch_total++;
         end else begin
            want = expected_rsp.pop_front();
            if (got.status !== want.status || got.found_handle !== want.found_handle ||
                got.slot_index !== want.slot_index ||
                got.entries_used !== want.entries_used) begin
               if (mismatch_total < REPORT_MAX)
                  $display({"mismatch: expected status %0d handle %h slot %0d used %0d,",
                            " got status %0d handle %h slot %0d used %0d"},
                           want.status, want.found_handle, want.slot_index,
                           want.entries_used, got.status, got.found_handle,
                           got.slot_index, got.entries_used);
               mismatch_total++;
            end
         end
      endfunction

      function bit passed();
         return mismatch_total == 0 && expected_rsp.size() == 0;
      endfunction
   endclass

   logic clock;
   logic reset;

   lphs_req_if req_chan();
   lphs_rsp_if rsp_chan();

   linear_probe_hash_set_top #(.CAPACITY(TABLE_SLOTS)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   hash_set_scoreboard tracker;
   hash_key_type       known_keys[$];
   int unsigned        send_idle_pct;
   int unsigned        rsp_stall_pct;
   int unsigned        hold_request;
   int unsigned        hold_left;
   int unsigned        cycle_count;
   int unsigned        sent_total;
   int unsigned        answered_total;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      set_request_type seen;
      if (!reset && req_chan.valid && req_chan.ready) begin
         seen = '{cmd: req_chan.cmd,
                  key: '{upper: req_chan.key_upper, middle: req_chan.key_middle,
                         lower: req_chan.key_lower},
                  handle: req_chan.object_handle};
         tracker.note_request(seen);
      end
   end

   always @(posedge clock) begin
      set_response_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{status: rsp_chan.status, found_handle: rsp_chan.found_handle,
                 slot_index: rsp_chan.slot_index, entries_used: rsp_chan.entries_used};
         tracker.check_response(got);
         answered_total++;
      end
   end

   // response back-pressure; a long hold-off is counted down here
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic set_request_type make_request(cmd_type cmd, hash_key_type key,
                                                    handle_type handle);
      set_request_type item;
      item.cmd    = cmd;
      item.key    = key;
      item.handle = handle;
      return item;
   endfunction

   // about a third of new keys land in a cluster across the wrap point
   function automatic hash_key_type fresh_key();
      hash_key_type k;
      k.upper  = {$urandom, $urandom};
      k.middle = {$urandom, $urandom};
      k.lower  = $urandom;
      if ($urandom_range(99) < 35)
         k.upper[32 +: SLOT_W] = slot_type'((TABLE_SLOTS - 6 + $urandom_range(9)) % TABLE_SLOTS);
      return k;
   endfunction

   function automatic hash_key_type known_key();
      if (known_keys.size() == 0) return fresh_key();
      return known_keys[$urandom_range(known_keys.size() - 1)];
   endfunction

   // a known key (a fresh one if none is known yet) with one bit flipped somewhere
   function automatic hash_key_type near_key();
      hash_key_type k;
      int unsigned  bit_pos;
      k       = known_key();
      bit_pos = $urandom_range($bits(hash_key_type) - 1);
      k[bit_pos] = ~k[bit_pos];
      return k;
   endfunction

   task automatic send_item(set_request_type item);
      req_chan.valid         <= 1'b1;
      req_chan.cmd           <= item.cmd;
      req_chan.key_upper     <= item.key.upper;
      req_chan.key_middle    <= item.key.middle;
      req_chan.key_lower     <= item.key.lower;
      req_chan.object_handle <= item.handle;
      do @(posedge clock); while (!req_chan.ready);
      sent_total++;
   endtask

   task automatic idle_gap();
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (answered_total != sent_total);
   endtask

   task automatic send_generated(bit filling);
      set_request_type item;
      int unsigned     roll;
      int unsigned     new_share;
      roll        = $urandom_range(99);
      item.handle = $urandom;
      if (filling && tracker.entry_total + 12 < LOAD_LIMIT) new_share = 96;
      else if (filling) new_share = 40;
      else new_share = 35;
      if (roll < new_share) begin
         item.cmd = CMD_INSERT;
         item.key = fresh_key();
         known_keys.push_back(item.key);
         if (known_keys.size() > TABLE_SLOTS) void'(known_keys.pop_front());
      end else if (roll < new_share + (100 - new_share) / 3) begin
         item.cmd = CMD_INSERT;
         item.key = known_key();
      end else if (!filling && roll >= 96) begin
         item.cmd = CMD_CLEAR;
         item.key = fresh_key();
      end else begin
         case ($urandom_range(3))
            0: item = make_request(CMD_LOOKUP, near_key(), item.handle);
            1: item = make_request(CMD_LOOKUP, fresh_key(), item.handle);
            2: item = make_request(CMD_SPARE, known_key(), item.handle);
            default: item = make_request(CMD_LOOKUP, known_key(), item.handle);
         endcase
      end
      idle_gap();
      send_item(item);
   endtask

   task automatic run_phase(bit filling, int unsigned count, int unsigned idle_pct,
                            int unsigned stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_generated(filling);
   endtask

   task automatic run_directed();
      hash_key_type zero_key;
      hash_key_type ones_key;
      hash_key_type wrap_key;
      hash_key_type near;
      zero_key = '0;
      ones_key = '1;
      wrap_key = '{upper: 64'h0000_03FF_0123_4567, middle: 64'h8000_0000_0000_0001,
                   lower: 32'h0F0F_F0F0};
      send_item(make_request(CMD_LOOKUP, ones_key, '0));
      send_item(make_request(CMD_INSERT, zero_key, '0));
      send_item(make_request(CMD_INSERT, ones_key, '1));
      // same home as the all-ones key: probes wrap past slot 0
      send_item(make_request(CMD_INSERT, wrap_key, 32'h5A5A_5A5A));
      send_item(make_request(CMD_LOOKUP, wrap_key, '0));
      send_item(make_request(CMD_INSERT, wrap_key, 32'hA5A5_A5A5));
      send_item(make_request(CMD_SPARE, ones_key, '0));
      near = wrap_key;
      near.lower[0] = ~near.lower[0];
      send_item(make_request(CMD_LOOKUP, near, '1));
      send_item(make_request(CMD_INSERT, near, 32'h0000_0001));
      near = wrap_key;
      near.middle[63] = ~near.middle[63];
      send_item(make_request(CMD_LOOKUP, near, '0));
      send_item(make_request(CMD_INSERT, zero_key, '1));
      near = zero_key;
      near.upper[0] = 1'b1;
      send_item(make_request(CMD_LOOKUP, near, '0));
      send_item(make_request(CMD_CLEAR, ones_key, '1));
      send_item(make_request(CMD_LOOKUP, ones_key, '0));
      send_item(make_request(CMD_INSERT, ones_key, 32'h0000_0001));
      send_item(make_request(CMD_CLEAR, zero_key, '0));
      send_item(make_request(CMD_CLEAR, zero_key, '0));
      send_item(make_request(CMD_LOOKUP, zero_key, '0));
   endtask

   initial begin
      tracker                = new();
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.cmd           = CMD_LOOKUP;
      req_chan.key_upper     = '0;
      req_chan.key_middle    = '0;
      req_chan.key_lower     = '0;
      req_chan.object_handle = '0;
      rsp_chan.ready         = 1'b0;
      send_idle_pct          = 0;
      rsp_stall_pct          = 0;
      hold_request           = 0;
      hold_left              = 0;
      cycle_count            = 0;
      sent_total             = 0;
      answered_total         = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      wait_drained();

      run_phase(1'b0, 60, 0, 0);
      send_item(make_request(CMD_CLEAR, fresh_key(), $urandom));
      wait_drained();

      // fill toward half load without clearing
      run_phase(1'b1, 180, 62, 0);
      wait_drained();
      hold_request = HOLD_CYCLES;
      run_phase(1'b1, 180, 0, 62);
      wait_drained();
      run_phase(1'b1, 260, 12, 12);
      send_item(make_request(CMD_CLEAR, fresh_key(), $urandom));
      send_item(make_request(CMD_LOOKUP, known_key(), $urandom));
      wait_drained();

      repeat (TABLE_SLOTS + 64) @(posedge clock);
      if (tracker.passed()) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== linear_probe_hash_set_top.f =====
sv/lphs_pkg.sv
sv/lphs_req_if.sv
sv/lphs_rsp_if.sv
sv/lphs_ram.sv
sv/linear_probe_hash_set_top.sv
tb/sv/tb_linear_probe_hash_set_top.sv
